[rtl/mm3_pkg.sv]
// Package for the MurmurHash3 x86_128 stream hash: channel payload types,
// datapath command codes, mixing constants and small helper functions.
// Depends on nothing; every other file of the block imports it.
package mm3_pkg;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  byte_count;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } out_item_t;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH = 1'd1;

    localparam int unsigned OP_W = 4;
    localparam logic [OP_W-1:0] OP_IDLE   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [OP_W-1:0] OP_KEY1   = 4'd2;
    localparam logic [OP_W-1:0] OP_KEY2   = 4'd3;
    localparam logic [OP_W-1:0] OP_BODY_A = 4'd4;
    localparam logic [OP_W-1:0] OP_BODY_B = 4'd5;
    localparam logic [OP_W-1:0] OP_PART   = 4'd6;
    localparam logic [OP_W-1:0] OP_FIN1   = 4'd7;
    localparam logic [OP_W-1:0] OP_FIN2   = 4'd8;
    localparam logic [OP_W-1:0] OP_FIN3   = 4'd9;
    localparam logic [OP_W-1:0] OP_FIN4   = 4'd10;
    localparam logic [OP_W-1:0] OP_FIN5   = 4'd11;
    localparam logic [OP_W-1:0] OP_FIN6   = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic full_block;
        logic last_block;
    } dp_status_t;

    localparam logic [4:0] FULL_COUNT = 5'd16;

    localparam logic [31:0] KEY_MA [4] = '{32'h239b961b, 32'hab0e9789,
                                           32'h38b34ae5, 32'ha1e38b93};
    localparam logic [31:0] KEY_MB [4] = '{32'hab0e9789, 32'h38b34ae5,
                                           32'ha1e38b93, 32'h239b961b};
    localparam logic [4:0]  KEY_ROT [4]  = '{5'd15, 5'd16, 5'd17, 5'd18};
    localparam logic [4:0]  LANE_ROT [4] = '{5'd19, 5'd17, 5'd15, 5'd13};
    localparam logic [31:0] LANE_N [4] = '{32'h561ccd1b, 32'h0bcaa747,
                                           32'h96cd1c35, 32'h32ac3b17};
    localparam logic [31:0] FMIX_M1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_M2 = 32'hc2b2ae35;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        rotl32 = (x << r) | (x >> (6'd32 - {1'b0, r}));
    endfunction

    function automatic logic [31:0] times5(input logic [31:0] x);
        times5 = (x << 2) + x;
    endfunction

endpackage

[rtl/mm3_dp.sv]
// Datapath of the MurmurHash3 x86_128 stream hash: seed registers, key and
// lane registers, length counter and digest register, driven by op codes.
// Depends on mm3_pkg.
module mm3_dp
    import mm3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_wdata,
    input  in_item_t             in_data,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    output out_item_t            digest
);

    logic [63:0]  seed_low_reg, seed_high_reg;
    logic [31:0]  lanes_reg [4];
    logic [31:0]  lanes_next [4];
    logic [31:0]  keys_reg [4];
    logic [31:0]  keys_next [4];
    logic [31:0]  len_reg, len_next;
    logic         in_msg_reg, in_msg_next;
    logic         full_reg, full_next;
    logic         last_reg, last_next;
    out_item_t    digest_reg, digest_next;
    logic [4:0]   count_eff;
    logic [127:0] block_raw;
    logic [127:0] block_masked;

    assign count_eff = (!in_data.last || (in_data.byte_count > FULL_COUNT)) ?
                       FULL_COUNT : in_data.byte_count;
    assign block_raw = {in_data.block_high, in_data.block_low};

    for (genvar j = 0; j < 16; j++) begin : g_mask
        assign block_masked[8*j +: 8] = (5'(j) < count_eff) ? block_raw[8*j +: 8] : 8'd0;
    end

    always_comb
    begin
        lanes_next  = lanes_reg;
        keys_next   = keys_reg;
        len_next    = len_reg;
        in_msg_next = in_msg_reg;
        full_next   = full_reg;
        last_next   = last_reg;
        digest_next = digest_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                if (!in_msg_reg)
                begin
                    lanes_next[0] = seed_low_reg[31:0];
                    lanes_next[1] = seed_low_reg[63:32];
                    lanes_next[2] = seed_high_reg[31:0];
                    lanes_next[3] = seed_high_reg[63:32];
                end
                len_next    = (in_msg_reg ? len_reg : 32'd0) + {27'd0, count_eff};
                in_msg_next = 1'b1;
                full_next   = (count_eff == FULL_COUNT);
                last_next   = in_data.last;
                for (int i = 0; i < 4; i++)
                begin
                    keys_next[i] = block_masked[32*i +: 32];
                end
            end
            OP_KEY1:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    keys_next[i] = keys_reg[i] * KEY_MA[i];
                end
            end
            OP_KEY2:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    keys_next[i] = rotl32(keys_reg[i], KEY_ROT[i]) * KEY_MB[i];
                end
            end
            OP_BODY_A:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lanes_next[i] = times5(rotl32(lanes_reg[i] ^ keys_reg[i], LANE_ROT[i])
                                           + lanes_reg[i+1]) + LANE_N[i];
                end
            end
            OP_BODY_B:
            begin
                lanes_next[3] = times5(rotl32(lanes_reg[3] ^ keys_reg[3], LANE_ROT[3])
                                       + lanes_reg[0]) + LANE_N[3];
            end
            OP_PART:
            begin
                // Lanes past the byte count carry a zero key, which mixes to zero.
                for (int i = 0; i < 4; i++)
                begin
                    lanes_next[i] = lanes_reg[i] ^ keys_reg[i];
                end
            end
            OP_FIN1:
            begin
                lanes_next[0] = (lanes_reg[0] ^ len_reg) + (lanes_reg[1] ^ len_reg)
                              + (lanes_reg[2] ^ len_reg) + (lanes_reg[3] ^ len_reg);
                for (int i = 1; i < 4; i++)
                begin
                    lanes_next[i] = lanes_reg[i] ^ len_reg;
                end
                in_msg_next = 1'b0;
            end
            OP_FIN2:
            begin
                for (int i = 1; i < 4; i++)
                begin
                    lanes_next[i] = lanes_reg[i] + lanes_reg[0];
                end
            end
            OP_FIN3:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lanes_next[i] = (lanes_reg[i] ^ (lanes_reg[i] >> 16)) * FMIX_M1;
                end
            end
            OP_FIN4:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lanes_next[i] = (lanes_reg[i] ^ (lanes_reg[i] >> 13)) * FMIX_M2;
                end
            end
            OP_FIN5:
            begin
                lanes_next[0] = (lanes_reg[0] ^ (lanes_reg[0] >> 16))
                              + (lanes_reg[1] ^ (lanes_reg[1] >> 16))
                              + (lanes_reg[2] ^ (lanes_reg[2] >> 16))
                              + (lanes_reg[3] ^ (lanes_reg[3] >> 16));
                for (int i = 1; i < 4; i++)
                begin
                    lanes_next[i] = lanes_reg[i] ^ (lanes_reg[i] >> 16);
                end
            end
            OP_FIN6:
            begin
                digest_next.digest_low  = {lanes_reg[1] + lanes_reg[0], lanes_reg[0]};
                digest_next.digest_high = {lanes_reg[3] + lanes_reg[0],
                                           lanes_reg[2] + lanes_reg[0]};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_low_reg  <= 64'd0;
            seed_high_reg <= 64'd0;
            len_reg       <= 32'd0;
            in_msg_reg    <= 1'b0;
            full_reg      <= 1'b0;
            last_reg      <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                lanes_reg[i] <= 32'd0;
            end
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_SEED_LOW))
            begin
                seed_low_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_SEED_HIGH))
            begin
                seed_high_reg <= cfg_wdata;
            end
            len_reg    <= len_next;
            in_msg_reg <= in_msg_next;
            full_reg   <= full_next;
            last_reg   <= last_next;
            lanes_reg  <= lanes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keys_reg   <= keys_next;
        digest_reg <= digest_next;
    end

    assign status.full_block = full_reg;
    assign status.last_block = last_reg;
    assign digest            = digest_reg;

endmodule

[rtl/mm3_ctrl.sv]
// Controller of the MurmurHash3 x86_128 stream hash: sequences key mixing,
// lane updates and finalization, and owns both channel handshakes.
// Depends on mm3_pkg.
module mm3_ctrl
    import mm3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_KEY1   = 4'd1;
    localparam logic [3:0] S_KEY2   = 4'd2;
    localparam logic [3:0] S_BODY_A = 4'd3;
    localparam logic [3:0] S_BODY_B = 4'd4;
    localparam logic [3:0] S_PART   = 4'd5;
    localparam logic [3:0] S_FIN1   = 4'd6;
    localparam logic [3:0] S_FIN2   = 4'd7;
    localparam logic [3:0] S_FIN3   = 4'd8;
    localparam logic [3:0] S_FIN4   = 4'd9;
    localparam logic [3:0] S_FIN5   = 4'd10;
    localparam logic [3:0] S_FIN6   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_KEY1;
                end
            end
            S_KEY1:
            begin
                cmd.op     = OP_KEY1;
                state_next = S_KEY2;
            end
            S_KEY2:
            begin
                cmd.op     = OP_KEY2;
                state_next = status.full_block ? S_BODY_A : S_PART;
            end
            S_BODY_A:
            begin
                cmd.op     = OP_BODY_A;
                state_next = S_BODY_B;
            end
            S_BODY_B:
            begin
                cmd.op     = OP_BODY_B;
                state_next = status.last_block ? S_FIN1 : S_IDLE;
            end
            S_PART:
            begin
                cmd.op     = OP_PART;
                state_next = status.last_block ? S_FIN1 : S_IDLE;
            end
            S_FIN1:
            begin
                cmd.op     = OP_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.op     = OP_FIN2;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                cmd.op     = OP_FIN3;
                state_next = S_FIN4;
            end
            S_FIN4:
            begin
                cmd.op     = OP_FIN4;
                state_next = S_FIN5;
            end
            S_FIN5:
            begin
                cmd.op     = OP_FIN5;
                state_next = S_FIN6;
            end
            S_FIN6:
            begin
                if (slot_free)
                begin
                    cmd.op     = OP_FIN6;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.op == OP_FIN6)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_digest_waits_for_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FIN6) |-> (!out_valid_reg || out_ready))
        else $error("Digest written while the output register is still occupied.");

    a_digest_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FIN6) |=> out_valid_reg)
        else $error("Digest written but no output transaction offered.");

    a_stall_holds_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN6 && out_valid_reg && !out_ready) |=> (state_reg == S_FIN6))
        else $error("Finalization left while the output was stalled.");
`endif

endmodule

[rtl/murmur3_128_stream_hash.sv]
// Top level of the MurmurHash3 x86_128 stream hash: channel ports, config port,
// controller and datapath. Depends on mm3_pkg, mm3_ctrl and mm3_dp.
//
// One transaction on the input carries a 16-byte little-endian block; a block
// with last set closes the message and yields one 128-bit digest transaction.
// Blocks are handled one at a time: a non-final full block passes from acceptance
// through the two registered key multiplies and the two-step lane chain (lane
// four needs the new lane one) before the next block is accepted. A final block
// then runs finalization states FIN1 to FIN6 (length xor, cross-adds, the two
// fmix multiplies and the final cross-add); FIN6 waits while the output register
// still holds an untaken digest; the digest waits there without blocking the
// next message. The seed is sampled when a message starts.
module murmur3_128_stream_hash
    import mm3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mm3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mm3_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .digest    (out_data)
    );

endmodule
